### src/lobm_pkg.sv
// shared types, codes and constants of the limit order book matcher
package lobm_pkg;

  localparam int ORDER_SLOTS_DEF = 32;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] OT_LIMIT  = 2'd0;
  localparam logic [1:0] OT_MARKET = 2'd1;
  localparam logic [1:0] OT_IOC    = 2'd2;
  localparam logic [1:0] OT_FOK    = 2'd3;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_PARTIAL   = 3'd1;
  localparam logic [2:0] ST_FILLED    = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  localparam logic RK_TRADE = 1'b0;
  localparam logic RK_FINAL = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SCAN_ID,
    DP_SCAN_FOK,
    DP_SCAN_BEST,
    DP_FILL,
    DP_CANCEL,
    DP_REST,
    DP_TOB_PRICE,
    DP_TOB_SUM,
    DP_FINAL
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       first;
    logic [2:0] status;
    logic       book_changed;
  } cmd_t;

  typedef struct packed {
    logic       is_cancel;
    logic       qty_zero;
    logic [1:0] order_type;
    logic       hit;
    logic       any_free;
    logic       fok_short;
    logic       best_found;
    logic       left_zero;
    logic       filled_nz;
  } stat_t;

endpackage

### src/lobm_in_if.sv
// order input channel
interface lobm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] ident;
  logic        side;
  logic [1:0]  order_type;
  logic [31:0] price;
  logic [31:0] quantity;

  modport source (output valid, kind, ident, side, order_type, price, quantity,
                  input ready);
  modport sink   (input valid, kind, ident, side, order_type, price, quantity,
                  output ready);
endinterface

### src/lobm_out_if.sv
// result output channel
interface lobm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] aggressor_id;
  logic [31:0] passive_id;
  logic [31:0] trade_price;
  logic [31:0] trade_qty;
  logic [2:0]  status;
  logic        book_changed;
  logic [31:0] bid_px;
  logic [31:0] bid_qty;
  logic [31:0] ask_px;
  logic [31:0] ask_qty;
  logic        last;

  modport source (output valid, result_kind, aggressor_id, passive_id, trade_price,
                  trade_qty, status, book_changed, bid_px, bid_qty, ask_px,
                  ask_qty, last, input ready);
  modport sink   (input valid, result_kind, aggressor_id, passive_id, trade_price,
                  trade_qty, status, book_changed, bid_px, bid_qty, ask_px,
                  ask_qty, last, output ready);
endinterface

### src/lobm_datapath.sv
// order slots, scan accumulators and result registers
module lobm_datapath #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  localparam int IDX_W = $clog2(ORDER_SLOTS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lobm_pkg::cmd_t       cmd_i,
  input  logic [IDX_W-1:0]     scan_idx_i,
  output lobm_pkg::stat_t      stat_o,
  input  logic                 kind_i,
  input  logic [31:0]          ident_i,
  input  logic                 side_i,
  input  logic [1:0]           order_type_i,
  input  logic [31:0]          price_i,
  input  logic [31:0]          quantity_i,
  output logic                 result_kind_o,
  output logic [31:0]          aggressor_id_o,
  output logic [31:0]          passive_id_o,
  output logic [31:0]          trade_price_o,
  output logic [31:0]          trade_qty_o,
  output logic [2:0]           status_o,
  output logic                 book_changed_o,
  output logic [31:0]          bid_px_o,
  output logic [31:0]          bid_qty_o,
  output logic [31:0]          ask_px_o,
  output logic [31:0]          ask_qty_o,
  output logic                 last_o
);

  localparam int AVW = 32 + IDX_W;

  logic [ORDER_SLOTS-1:0] valid_q;
  logic [31:0] ident_q [ORDER_SLOTS];
  logic        side_q  [ORDER_SLOTS];
  logic [31:0] price_q [ORDER_SLOTS];
  logic [31:0] left_q  [ORDER_SLOTS];
  logic [31:0] arr_q   [ORDER_SLOTS];
  logic [31:0] arr_cnt_q;

  // latched input word
  logic        kind_q, sd_q;
  logic [1:0]  ot_q;
  logic [31:0] id_q, px_q, qty_q, rem_q;

  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [AVW-1:0]   avail_q;
  logic             bf_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [31:0]      best_p_q, best_age_q, best_left_q, best_id_q;
  logic             bid_any_q, ask_any_q;
  logic [31:0]      bid_p_q, ask_p_q, bid_s_q, ask_s_q;

  logic             rv, rs;
  logic [31:0]      rid, rp, rl, age_w;
  logic             crosses_w, better_w;
  logic             any_free_w;
  logic [IDX_W-1:0] free_idx_w;
  logic [31:0]      fill_q_w;
  logic [32:0]      bid_sum_w, ask_sum_w;

  always_comb begin
    rv  = valid_q[scan_idx_i];
    rs  = side_q[scan_idx_i];
    rid = ident_q[scan_idx_i];
    rp  = price_q[scan_idx_i];
    rl  = left_q[scan_idx_i];
    age_w = arr_cnt_q - arr_q[scan_idx_i];
    crosses_w = rv && (rs != sd_q) &&
                ((ot_q == lobm_pkg::OT_MARKET) ||
                 ((sd_q == lobm_pkg::SIDE_BUY) ? (px_q >= rp) : (px_q <= rp)));
    if (rp != best_p_q) begin
      better_w = (sd_q == lobm_pkg::SIDE_BUY) ? (rp < best_p_q) : (rp > best_p_q);
    end else begin
      better_w = age_w > best_age_q;
    end
    fill_q_w  = (best_left_q < rem_q) ? best_left_q : rem_q;
    bid_sum_w = {1'b0, bid_s_q} + {1'b0, rl};
    ask_sum_w = {1'b0, ask_s_q} + {1'b0, rl};
  end

  // lowest free slot
  always_comb begin
    any_free_w = 1'b0;
    free_idx_w = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free_w = 1'b1;
        free_idx_w = IDX_W'(i);
      end
    end
  end

  always_comb begin
    stat_o.is_cancel  = (kind_q == lobm_pkg::KIND_CANCEL);
    stat_o.qty_zero   = (qty_q == 32'd0);
    stat_o.order_type = ot_q;
    stat_o.hit        = hit_q;
    stat_o.any_free   = any_free_w;
    stat_o.fok_short  = avail_q < {{IDX_W{1'b0}}, qty_q};
    stat_o.best_found = bf_q;
    stat_o.left_zero  = (rem_q == 32'd0);
    stat_o.filled_nz  = (rem_q != qty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      arr_cnt_q <= '0;
    end else begin
      unique case (cmd_i.op)
        lobm_pkg::DP_FILL: begin
          if (best_left_q == fill_q_w) valid_q[best_idx_q] <= 1'b0;
        end
        lobm_pkg::DP_CANCEL: valid_q[hit_idx_q] <= 1'b0;
        lobm_pkg::DP_REST: begin
          valid_q[free_idx_w] <= 1'b1;
          arr_cnt_q <= arr_cnt_q + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      lobm_pkg::DP_LOAD: begin
        kind_q <= kind_i;
        id_q   <= ident_i;
        sd_q   <= side_i;
        ot_q   <= order_type_i;
        px_q   <= price_i;
        qty_q  <= quantity_i;
        rem_q  <= quantity_i;
      end
      lobm_pkg::DP_SCAN_ID: begin
        if (cmd_i.first) hit_q <= 1'b0;
        if (rv && (rid == id_q) && (cmd_i.first || !hit_q)) begin
          hit_q     <= 1'b1;
          hit_idx_q <= scan_idx_i;
        end
      end
      lobm_pkg::DP_SCAN_FOK: begin
        if (crosses_w) begin
          avail_q <= (cmd_i.first ? '0 : avail_q) + {{IDX_W{1'b0}}, rl};
        end else if (cmd_i.first) begin
          avail_q <= '0;
        end
      end
      lobm_pkg::DP_SCAN_BEST: begin
        if (cmd_i.first) bf_q <= 1'b0;
        if (crosses_w && (cmd_i.first || !bf_q || better_w)) begin
          bf_q        <= 1'b1;
          best_idx_q  <= scan_idx_i;
          best_p_q    <= rp;
          best_age_q  <= age_w;
          best_left_q <= rl;
          best_id_q   <= rid;
        end
      end
      lobm_pkg::DP_FILL: begin
        left_q[best_idx_q] <= best_left_q - fill_q_w;
        rem_q          <= rem_q - fill_q_w;
        result_kind_o  <= lobm_pkg::RK_TRADE;
        aggressor_id_o <= id_q;
        passive_id_o   <= best_id_q;
        trade_price_o  <= best_p_q;
        trade_qty_o    <= fill_q_w;
        status_o       <= lobm_pkg::ST_NEW;
        book_changed_o <= 1'b0;
        bid_px_o       <= '0;
        bid_qty_o      <= '0;
        ask_px_o       <= '0;
        ask_qty_o      <= '0;
        last_o         <= 1'b0;
      end
      lobm_pkg::DP_REST: begin
        ident_q[free_idx_w] <= id_q;
        side_q[free_idx_w]  <= sd_q;
        price_q[free_idx_w] <= px_q;
        left_q[free_idx_w]  <= rem_q;
        arr_q[free_idx_w]   <= arr_cnt_q;
      end
      lobm_pkg::DP_TOB_PRICE: begin
        if (cmd_i.first) begin
          bid_any_q <= 1'b0;
          ask_any_q <= 1'b0;
        end
        if (rv && rs == lobm_pkg::SIDE_BUY &&
            (cmd_i.first || !bid_any_q || rp > bid_p_q)) begin
          bid_any_q <= 1'b1;
          bid_p_q   <= rp;
        end
        if (rv && rs == lobm_pkg::SIDE_SELL &&
            (cmd_i.first || !ask_any_q || rp < ask_p_q)) begin
          ask_any_q <= 1'b1;
          ask_p_q   <= rp;
        end
      end
      lobm_pkg::DP_TOB_SUM: begin
        // saturating sums of the lots resting at each best price
        if (rv && rs == lobm_pkg::SIDE_BUY && rp == bid_p_q) begin
          if (cmd_i.first) bid_s_q <= rl;
          else bid_s_q <= bid_sum_w[32] ? 32'hFFFF_FFFF : bid_sum_w[31:0];
        end else if (cmd_i.first) begin
          bid_s_q <= '0;
        end
        if (rv && rs == lobm_pkg::SIDE_SELL && rp == ask_p_q) begin
          if (cmd_i.first) ask_s_q <= rl;
          else ask_s_q <= ask_sum_w[32] ? 32'hFFFF_FFFF : ask_sum_w[31:0];
        end else if (cmd_i.first) begin
          ask_s_q <= '0;
        end
      end
      lobm_pkg::DP_FINAL: begin
        result_kind_o  <= lobm_pkg::RK_FINAL;
        aggressor_id_o <= id_q;
        passive_id_o   <= '0;
        trade_price_o  <= '0;
        trade_qty_o    <= qty_q - rem_q;
        status_o       <= cmd_i.status;
        book_changed_o <= cmd_i.book_changed;
        bid_px_o       <= bid_any_q ? bid_p_q : 32'd0;
        bid_qty_o      <= bid_any_q ? bid_s_q : 32'd0;
        ask_px_o       <= ask_any_q ? ask_p_q : 32'd0;
        ask_qty_o      <= ask_any_q ? ask_s_q : 32'd0;
        last_o         <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### src/lobm_ctrl.sv
// sequencer for id, fill-or-kill, best-price and top-of-book scans
module lobm_ctrl #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF,
  localparam int IDX_W = $clog2(ORDER_SLOTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lobm_pkg::cmd_t   cmd_o,
  output logic [IDX_W-1:0] scan_idx_o,
  input  lobm_pkg::stat_t  stat_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_IDSCAN = 4'd2;
  localparam logic [3:0] S_IDDONE = 4'd3;
  localparam logic [3:0] S_FOK    = 4'd4;
  localparam logic [3:0] S_FOKEND = 4'd5;
  localparam logic [3:0] S_BEST   = 4'd6;
  localparam logic [3:0] S_BESTEND= 4'd7;
  localparam logic [3:0] S_TOUT   = 4'd8;
  localparam logic [3:0] S_AFTER  = 4'd9;
  localparam logic [3:0] S_TOB1   = 4'd10;
  localparam logic [3:0] S_TOB2   = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;
  localparam logic [3:0] S_FOUT   = 4'd13;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [2:0]       st_q, st_d;
  logic             bc_q, bc_d;
  logic             last_w;

  assign scan_idx_o  = cnt_q;
  assign last_w      = (cnt_q == LAST_IDX);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_TOUT) || (state_q == S_FOUT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    bc_d    = bc_q;
    cmd_o.op           = lobm_pkg::DP_NOP;
    cmd_o.first        = (cnt_q == '0);
    cmd_o.status       = st_q;
    cmd_o.book_changed = bc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = lobm_pkg::DP_LOAD;
          state_d  = S_START;
        end
      end
      S_START: begin
        cnt_d = '0;
        if (!stat_i.is_cancel && stat_i.qty_zero) begin
          st_d = lobm_pkg::ST_REJECTED;
          bc_d = 1'b0;
          state_d = S_TOB1;
        end else begin
          state_d = S_IDSCAN;
        end
      end
      S_IDSCAN: begin
        cmd_o.op = lobm_pkg::DP_SCAN_ID;
        cnt_d = last_w ? '0 : cnt_q + 1'b1;
        if (last_w) state_d = S_IDDONE;
      end
      S_IDDONE: begin
        bc_d = 1'b0;
        if (stat_i.is_cancel) begin
          if (stat_i.hit) begin
            cmd_o.op = lobm_pkg::DP_CANCEL;
            st_d = lobm_pkg::ST_CANCELLED;
            bc_d = 1'b1;
          end else begin
            st_d = lobm_pkg::ST_REJECTED;
          end
          state_d = S_TOB1;
        end else if (stat_i.hit ||
                     (stat_i.order_type == lobm_pkg::OT_LIMIT && !stat_i.any_free)) begin
          st_d = lobm_pkg::ST_REJECTED;
          state_d = S_TOB1;
        end else if (stat_i.order_type == lobm_pkg::OT_FOK) begin
          state_d = S_FOK;
        end else begin
          state_d = S_BEST;
        end
      end
      S_FOK: begin
        cmd_o.op = lobm_pkg::DP_SCAN_FOK;
        cnt_d = last_w ? '0 : cnt_q + 1'b1;
        if (last_w) state_d = S_FOKEND;
      end
      S_FOKEND: begin
        if (stat_i.fok_short) begin
          st_d = lobm_pkg::ST_CANCELLED;
          state_d = S_TOB1;
        end else begin
          state_d = S_BEST;
        end
      end
      S_BEST: begin
        cmd_o.op = lobm_pkg::DP_SCAN_BEST;
        cnt_d = last_w ? '0 : cnt_q + 1'b1;
        if (last_w) state_d = S_BESTEND;
      end
      S_BESTEND: begin
        if (stat_i.best_found) begin
          cmd_o.op = lobm_pkg::DP_FILL;
          state_d  = S_TOUT;
        end else begin
          state_d = S_AFTER;
        end
      end
      S_TOUT: begin
        if (out_ready_i) begin
          if (stat_i.left_zero) begin
            st_d = lobm_pkg::ST_FILLED;
            state_d = S_TOB1;
          end else begin
            state_d = S_BEST;
          end
        end
      end
      S_AFTER: begin
        // remainder of a limit order rests if a slot is free, anything else is cancelled
        if (stat_i.order_type != lobm_pkg::OT_LIMIT || !stat_i.any_free) begin
          st_d = lobm_pkg::ST_CANCELLED;
        end else begin
          cmd_o.op = lobm_pkg::DP_REST;
          st_d = stat_i.filled_nz ? lobm_pkg::ST_PARTIAL : lobm_pkg::ST_NEW;
          bc_d = 1'b1;
        end
        state_d = S_TOB1;
      end
      S_TOB1: begin
        cmd_o.op = lobm_pkg::DP_TOB_PRICE;
        cnt_d = last_w ? '0 : cnt_q + 1'b1;
        if (last_w) state_d = S_TOB2;
      end
      S_TOB2: begin
        cmd_o.op = lobm_pkg::DP_TOB_SUM;
        cnt_d = last_w ? '0 : cnt_q + 1'b1;
        if (last_w) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = lobm_pkg::DP_FINAL;
        state_d  = S_FOUT;
      end
      S_FOUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      st_q    <= lobm_pkg::ST_NEW;
      bc_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
      bc_q    <= bc_d;
    end
  end

endmodule

### src/limit_order_book_matcher.sv
// limit order book matcher top level
// Usage: orders come in on in_i (add or cancel), results leave on out_o.
// One input word at a time is taken; in_i.ready is high only while the
// block is idle. Each input gives zero or more trade words followed by one
// final word (last set) with status and top of book.
// Every pass over the order slots reads one slot per cycle through a
// single read port of the slot registers; no pass stalls. Passes per
// input word:
//   cancel or rejected add: id scan + two top-of-book passes;
//   an add of zero quantity skips the id scan
//   add filled completely by T trades: id scan, T best-price passes
//   (one per trade) and the two top-of-book passes
//   an unfilled remainder adds one more best-price pass,
//   and a fill-or-kill order adds its sum pass
// Each result word sits in an output register until out_o.ready; a
// stalled receiver holds the sequencer, nothing is dropped.
// Reset empties the book at once (valid bits cleared) and zeroes the
// arrival counter; no clearing pass is needed.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lobm_in_if.sink     in_i,
  lobm_out_if.source  out_o
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);

  lobm_pkg::cmd_t   cmd;
  lobm_pkg::stat_t  stat;
  logic [IDX_W-1:0] scan_idx;

  lobm_ctrl #(.ORDER_SLOTS(ORDER_SLOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .scan_idx_o  (scan_idx),
    .stat_i      (stat)
  );

  lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .scan_idx_i     (scan_idx),
    .stat_o         (stat),
    .kind_i         (in_i.kind),
    .ident_i        (in_i.ident),
    .side_i         (in_i.side),
    .order_type_i   (in_i.order_type),
    .price_i        (in_i.price),
    .quantity_i     (in_i.quantity),
    .result_kind_o  (out_o.result_kind),
    .aggressor_id_o (out_o.aggressor_id),
    .passive_id_o   (out_o.passive_id),
    .trade_price_o  (out_o.trade_price),
    .trade_qty_o    (out_o.trade_qty),
    .status_o       (out_o.status),
    .book_changed_o (out_o.book_changed),
    .bid_px_o       (out_o.bid_px),
    .bid_qty_o      (out_o.bid_qty),
    .ask_px_o       (out_o.ask_px),
    .ask_qty_o      (out_o.ask_qty),
    .last_o         (out_o.last)
  );

`ifndef SYNTHESIS
  a_no_accept_while_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input accepted while a result word is pending");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready stayed high after an accepted word");

  a_idle_after_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("not idle after the final word");

  a_final_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == out_o.result_kind))
    else $error("last flag and result kind disagree");
`endif

endmodule
